// ----- design/pmtq_pkg.sv -----
`default_nettype none
package pmtq_pkg;

  localparam int PHASE_W   = 3;
  localparam int MASK_W    = 8;
  localparam int IN_TAG_W  = 32;
  localparam int OUT_TAG_W = 32;
  localparam int CNT_OUT_W = 6;
  localparam int CFG_W     = 32;
  localparam int CFG_AW    = 3;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic REG_IDLE_PHASE = 1'b0;

  typedef struct packed {
    logic enq;
    logic rot;
    logic keep;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- design/pmtq_cell.sv -----
`default_nettype none
module pmtq_cell #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 32,
  parameter int IDX         = 0,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  pmtq_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]        fill,
  input  logic [TAG_BITS-1:0]     in_tag,
  input  logic [pmtq_pkg::MASK_W-1:0] in_mask,
  input  logic [TAG_BITS-1:0]     nbr_tag,
  input  logic [pmtq_pkg::MASK_W-1:0] nbr_mask,
  input  logic [TAG_BITS-1:0]     head_tag,
  input  logic [pmtq_pkg::MASK_W-1:0] head_mask,
  output logic [TAG_BITS-1:0]     tag,
  output logic [pmtq_pkg::MASK_W-1:0] mask
);
  import pmtq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W:0]   IDX_P1 = (CNT_W + 1)'(IDX + 1);

  logic [TAG_BITS-1:0] tag_r;
  logic [MASK_W-1:0]   mask_r;
  logic                enq_here;
  logic                below_tail;
  logic                at_tail;

  assign enq_here   = ctrl.enq && (fill == IDX_C);
  assign below_tail = {1'b0, fill} > IDX_P1;
  assign at_tail    = {1'b0, fill} == IDX_P1;

  always_ff @(posedge clk) begin
    if (enq_here) begin
      tag_r  <= in_tag;
      mask_r <= in_mask;
    end else if (ctrl.rot && below_tail) begin
      tag_r  <= nbr_tag;
      mask_r <= nbr_mask;
    end else if (ctrl.rot && at_tail && ctrl.keep) begin
      tag_r  <= head_tag;
      mask_r <= head_mask;
    end
  end

  assign tag  = tag_r;
  assign mask = mask_r;

endmodule
`default_nettype wire

// ----- design/phase_masked_task_queue_core.sv -----
// phase-masked task queue, oldest-ready select
//
// input channel (in_valid / in_stall): one beat per command. opcode enqueue
// appends in_task_tag / in_task_phases at the tail, or flags dropped when the
// queue is full. opcode dequeue removes the oldest entry whose mask has the
// in_phase_now bit set, else the oldest with the idle_phase bit set.
// result channel (out_valid / out_stall): exactly one beat per command,
// carrying the pending count after the command.
// enqueue and dequeue of an empty queue: result registered in the output
// register on acceptance. dequeue of a non-empty queue: the entries are
// rotated through the head cell one per cycle, in at most two passes, and
// the result then waits in ST_DONE until the output register is free.
// a new command can be taken in the cycle after a result is registered,
// when out_stall is low and that result leaves the output register.
// out_stall holds the result register; in_stall rises while a command is in
// work or while a result is held and cannot yet be replaced.
// reset empties the queue, clears idle_phase and the output valid.
// idle_phase is written through the cfg_ apb port at byte addresses 0 to 3.
`default_nettype none
module phase_masked_task_queue_core #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic [pmtq_pkg::IN_TAG_W-1:0]      in_task_tag,
  input  logic [pmtq_pkg::MASK_W-1:0]        in_task_phases,
  input  logic [pmtq_pkg::PHASE_W-1:0]       in_phase_now,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic                               out_via_fallback,
  output logic [pmtq_pkg::OUT_TAG_W-1:0]     out_task_out,
  output logic [pmtq_pkg::MASK_W-1:0]        out_phases_out,
  output logic                               out_dropped,
  output logic [pmtq_pkg::CNT_OUT_W-1:0]     out_pending_count,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pmtq_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [pmtq_pkg::CFG_W-1:0]         cfg_pwdata,
  output logic [pmtq_pkg::CFG_W-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import pmtq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     fill_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pass_r;
  logic                 removed_r;
  logic [PHASE_W-1:0]   phase_r;
  logic [PHASE_W-1:0]   idle_phase_r;
  logic                 res_found_r;
  logic                 res_via_r;
  logic [OUT_TAG_W-1:0] res_tag_r;
  logic [MASK_W-1:0]    res_mask_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic                 out_via_r;
  logic [OUT_TAG_W-1:0] out_tag_r;
  logic [MASK_W-1:0]    out_mask_r;
  logic                 out_dropped_r;
  logic [CNT_OUT_W-1:0] out_pending_r;

  logic [TAG_BITS-1:0]  cell_tag  [QUEUE_DEPTH+1];
  logic [MASK_W-1:0]    cell_mask [QUEUE_DEPTH+1];
  logic [TAG_BITS-1:0]  in_tag_st;
  logic [63:0]          in_tag_ext;
  logic [63:0]          head_tag_ext;
  cell_ctrl_t           ctrl;
  logic                 out_free;
  logic                 out_load;
  logic                 in_acc;
  logic                 cfg_wr;
  logic                 full;
  logic [PHASE_W-1:0]   sel_phase;
  logic                 hit;
  logic [CNT_W-1:0]     fill_inc;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE) || !out_free;
  assign in_acc     = in_valid && !in_stall;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDLE_PHASE) ? CFG_W'(idle_phase_r) : '0;

  assign out_load   = (in_acc && ((in_opcode == OP_ENQ) || (fill_r == '0))) ||
                      ((state_r == ST_DONE) && out_free);

  assign full       = fill_r == DEPTH_C;
  assign fill_inc   = fill_r + 1'b1;
  assign sel_phase  = pass_r ? idle_phase_r : phase_r;
  assign hit        = (state_r == ST_SCAN) && !removed_r && cell_mask[0][sel_phase];

  assign in_tag_ext   = 64'(in_task_tag);
  assign in_tag_st    = in_tag_ext[TAG_BITS-1:0];
  assign head_tag_ext = 64'(cell_tag[0]);

  assign ctrl.enq  = in_acc && (in_opcode == OP_ENQ) && !full;
  assign ctrl.rot  = state_r == ST_SCAN;
  assign ctrl.keep = !hit;

  assign cell_tag[QUEUE_DEPTH]  = '0;
  assign cell_mask[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pmtq_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TAG_BITS   (TAG_BITS),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .fill     (fill_r),
      .in_tag   (in_tag_st),
      .in_mask  (in_task_phases),
      .nbr_tag  (cell_tag[i+1]),
      .nbr_mask (cell_mask[i+1]),
      .head_tag (cell_tag[0]),
      .head_mask(cell_mask[0]),
      .tag      (cell_tag[i]),
      .mask     (cell_mask[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      cnt_r        <= '0;
      pass_r       <= 1'b0;
      removed_r    <= 1'b0;
      idle_phase_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr[2] == REG_IDLE_PHASE)) begin
        idle_phase_r <= cfg_pwdata[PHASE_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_opcode == OP_ENQ) begin
              out_found_r   <= 1'b0;
              out_via_r     <= 1'b0;
              out_tag_r     <= '0;
              out_mask_r    <= '0;
              out_dropped_r <= full;
              out_pending_r <= full ? CNT_OUT_W'(fill_r) : CNT_OUT_W'(fill_inc);
              if (!full) begin
                fill_r <= fill_inc;
              end
            end else if (fill_r == '0) begin
              out_found_r   <= 1'b0;
              out_via_r     <= 1'b0;
              out_tag_r     <= '0;
              out_mask_r    <= '0;
              out_dropped_r <= 1'b0;
              out_pending_r <= '0;
            end else begin
              state_r     <= ST_SCAN;
              cnt_r       <= fill_r;
              pass_r      <= 1'b0;
              removed_r   <= 1'b0;
              phase_r     <= in_phase_now;
              res_found_r <= 1'b0;
              res_via_r   <= 1'b0;
              res_tag_r   <= '0;
              res_mask_r  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            removed_r   <= 1'b1;
            fill_r      <= fill_r - 1'b1;
            res_found_r <= 1'b1;
            res_via_r   <= pass_r;
            res_tag_r   <= head_tag_ext[OUT_TAG_W-1:0];
            res_mask_r  <= cell_mask[0];
          end
          if (cnt_r == ONE_C) begin
            if (hit || removed_r) begin
              state_r <= ST_DONE;
            end else if (!pass_r && (idle_phase_r != phase_r)) begin
              pass_r <= 1'b1;
              cnt_r  <= fill_r;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_found_r   <= res_found_r;
            out_via_r     <= res_via_r;
            out_tag_r     <= res_tag_r;
            out_mask_r    <= res_mask_r;
            out_dropped_r <= 1'b0;
            out_pending_r <= CNT_OUT_W'(fill_r);
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_via_fallback  = out_via_r;
  assign out_task_out      = out_tag_r;
  assign out_phases_out    = out_mask_r;
  assign out_dropped       = out_dropped_r;
  assign out_pending_count = out_pending_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("queue fill above depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_opcode == OP_ENQ) && !full) |=> (fill_r == $past(fill_inc)))
    else $error("enqueue did not grow the queue");

  a_found_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_found_r && out_dropped_r))
    else $error("result both found and dropped");

  a_scan_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && removed_r) |-> !hit)
    else $error("second removal in one dequeue");

endmodule
`default_nettype wire
